// ----- design/stc_pkg.sv -----
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for the slot table
// Table geometry, request/response payloads, op and status codes, cell link.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int TAG_BITS      = 16;

    localparam int IDX_W      = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_IN_W  = 5;
    // wide enough for slot_index, any cell number and TABLE_ENTRIES itself
    localparam int SLOT_CMP_W = ((IDX_W > SLOT_IN_W) ? IDX_W : SLOT_IN_W) + 1;

    localparam logic signed [31:0] KEY_NONE = -32'sd1;

    typedef enum logic [1:0] {
        FN_INSERT  = 2'd0,
        FN_RESERVE = 2'd1,
        FN_SEARCH  = 2'd2,
        FN_REMOVE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_MISS  = 2'd1,
        STS_RANGE = 2'd2,
        STS_FREE  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] conn_key;
        logic [15:0]        conn_handle;
        logic [4:0]         slot_index;
    } req_t;

    typedef struct packed {
        logic [3:0]  slot;
        logic [1:0]  status;
        logic [15:0] seq_tag;
        logic [15:0] freed_handle;
    } rsp_t;

    // broadcast to every cell during the run cycle
    typedef struct packed {
        logic               active;
        func_t              func;
        logic signed [31:0] key;
        logic [15:0]        handle;
        logic [TAG_BITS-1:0] tag;
    } cell_cmd_t;

    // passed from cell to cell; the lowest hitting cell claims it
    typedef struct packed {
        logic                found;
        logic [IDX_W-1:0]    idx;
        logic                valid;
        logic [TAG_BITS-1:0] tag;
        logic [15:0]         handle;
    } cell_link_t;

endpackage

// ----- design/stc_cell.sv -----
// ----------------------------------------------------------------------------
// stc_cell: one table entry
// Holds valid/key/handle/tag, tests the request, claims the link if first hit.
// ----------------------------------------------------------------------------
module stc_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  stc_pkg::cell_cmd_t               cmd,
    input  logic [stc_pkg::IDX_W-1:0]        cell_idx,
    input  logic                             target,
    input  stc_pkg::cell_link_t              link_in,
    output stc_pkg::cell_link_t              link_out
);

    logic                         valid_reg, valid_next;
    logic signed [31:0]           key_reg, key_next;
    logic [15:0]                  handle_reg, handle_next;
    logic [stc_pkg::TAG_BITS-1:0] tag_reg, tag_next;
    logic                         hit;
    logic                         sel;

    always_comb
    begin
        case (cmd.func)
            stc_pkg::FN_INSERT,
            stc_pkg::FN_RESERVE: hit = !valid_reg;
            stc_pkg::FN_SEARCH:  hit = valid_reg && (key_reg == cmd.key);
            stc_pkg::FN_REMOVE:  hit = target;
            default:             hit = 1'b0;
        endcase
        sel = cmd.active && hit && !link_in.found;
    end

    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        tag_next    = tag_reg;
        if (sel)
        begin
            case (cmd.func)
                stc_pkg::FN_INSERT:
                begin
                    valid_next  = 1'b1;
                    key_next    = cmd.key;
                    handle_next = cmd.handle;
                    tag_next    = cmd.tag;
                end
                stc_pkg::FN_RESERVE:
                begin
                    valid_next = 1'b1;
                    tag_next   = cmd.tag;
                end
                stc_pkg::FN_REMOVE:
                begin
                    if (valid_reg)
                    begin
                        valid_next  = 1'b0;
                        key_next    = stc_pkg::KEY_NONE;
                        handle_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        link_out = link_in;
        if (sel)
        begin
            link_out.found  = 1'b1;
            link_out.idx    = cell_idx;
            link_out.valid  = valid_reg;
            link_out.tag    = tag_reg;
            link_out.handle = handle_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            key_reg    <= stc_pkg::KEY_NONE;
            handle_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            key_reg    <= key_next;
            handle_reg <= handle_next;
        end
    end

    // tag is only read back from a valid entry
    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

endmodule

// ----- design/slot_table_alloc_search.sv -----
// ----------------------------------------------------------------------------
// slot_table_alloc_search: slot table with first-free allocate and key search
// Result: the edge that accepts a request moves the block into the run state,
//   and done is set as the run state ends. Busy covers the single run cycle,
//   which holds the ripple priority pick along the row of entry cells.
// The receiver cannot stall: a result is shown for one cycle and a new
//   request may be taken while it is shown.
// Reset: asynchronous, clears every entry at once; no clearing pass.
// ----------------------------------------------------------------------------
module slot_table_alloc_search (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  stc_pkg::req_t req,
    output logic          done,
    output stc_pkg::rsp_t rsp
);

    localparam int N = stc_pkg::TABLE_ENTRIES;

    // control
    stc_pkg::state_t state_reg, state_next;
    stc_pkg::req_t   req_reg, req_next;

    // table bookkeeping
    logic [stc_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [stc_pkg::TAG_BITS-1:0] tag_reg, tag_next;

    // result register
    logic          done_reg, done_next;
    stc_pkg::rsp_t rsp_reg, rsp_next;

    // cell row
    stc_pkg::cell_cmd_t  cmd;
    stc_pkg::cell_link_t link [0:N];
    logic [N-1:0]        target;
    logic                out_of_range;
    logic                full;
    logic                accept;

    assign accept = start && (state_reg == stc_pkg::S_IDLE);
    assign busy   = (state_reg != stc_pkg::S_IDLE);
    assign done   = done_reg;
    assign rsp    = rsp_reg;

    // broadcast of the held request to every cell
    always_comb
    begin
        cmd.active = (state_reg == stc_pkg::S_RUN);
        cmd.func   = stc_pkg::func_t'(req_reg.func);
        cmd.key    = req_reg.conn_key;
        cmd.handle = req_reg.conn_handle;
        cmd.tag    = tag_reg;
    end

    assign out_of_range = stc_pkg::SLOT_CMP_W'(req_reg.slot_index)
                          >= stc_pkg::SLOT_CMP_W'(N);
    assign full         = count_reg >= stc_pkg::CNT_W'(N);

    // row of cells: link[0] enters empty, the first hitting cell claims it
    assign link[0] = '0;

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            assign target[g] = stc_pkg::SLOT_CMP_W'(req_reg.slot_index)
                               == stc_pkg::SLOT_CMP_W'(g);
            stc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .cell_idx (stc_pkg::IDX_W'(g)),
                .target   (target[g]),
                .link_in  (link[g]),
                .link_out (link[g+1])
            );
        end
    endgenerate

    // next state, bookkeeping and result
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        tag_next   = tag_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;

        case (state_reg)
            stc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = req;
                    state_next = stc_pkg::S_RUN;
                end
            end
            stc_pkg::S_RUN:
            begin
                state_next = stc_pkg::S_IDLE;
                done_next  = 1'b1;
                rsp_next   = '0;
                rsp_next.status = stc_pkg::STS_MISS;
                case (stc_pkg::func_t'(req_reg.func))
                    stc_pkg::FN_INSERT,
                    stc_pkg::FN_RESERVE:
                    begin
                        if (link[N].found && !full)
                        begin
                            rsp_next.slot    = 4'(link[N].idx);
                            rsp_next.status  = stc_pkg::STS_OK;
                            rsp_next.seq_tag = 16'(tag_reg);
                            tag_next         = tag_reg + 1'b1;
                            count_next       = count_reg + 1'b1;
                        end
                    end
                    stc_pkg::FN_SEARCH:
                    begin
                        if (link[N].found)
                        begin
                            rsp_next.slot    = 4'(link[N].idx);
                            rsp_next.status  = stc_pkg::STS_OK;
                            rsp_next.seq_tag = 16'(link[N].tag);
                        end
                    end
                    stc_pkg::FN_REMOVE:
                    begin
                        if (out_of_range)
                        begin
                            rsp_next.status = stc_pkg::STS_RANGE;
                        end
                        else if (!link[N].found || !link[N].valid)
                        begin
                            rsp_next.status = stc_pkg::STS_FREE;
                        end
                        else
                        begin
                            rsp_next.slot         = 4'(link[N].idx);
                            rsp_next.status       = stc_pkg::STS_OK;
                            rsp_next.seq_tag      = 16'(link[N].tag);
                            rsp_next.freed_handle = link[N].handle;
                            count_next            = count_reg - 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
                state_next = stc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stc_pkg::S_IDLE;
            count_reg <= '0;
            tag_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            tag_reg   <= tag_next;
            done_reg  <= done_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    // a result only follows a run cycle
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == stc_pkg::S_RUN))
        else $error("result without a run cycle");

    // the cycle after a run cycle always shows a result, with the block idle again
    a_run_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stc_pkg::S_RUN) |=> (done && !busy))
        else $error("run cycle did not end with a result");

    // occupancy never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= stc_pkg::CNT_W'(N))
        else $error("occupancy count above table size");

    // a successful allocate grows occupancy by one and advances the tag
    a_alloc_books: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stc_pkg::S_RUN && rsp_next.status == stc_pkg::STS_OK
         && (req_reg.func == stc_pkg::FN_INSERT || req_reg.func == stc_pkg::FN_RESERVE))
        |=> (count_reg == $past(count_reg) + 1'b1 && tag_reg == $past(tag_reg) + 1'b1))
        else $error("allocate bookkeeping mismatch");

endmodule

// ----- verif/slot_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_checker: result predictor and comparator for the slot table
// Keeps a shadow table, computes each accepted request's result, and checks
// every done strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module slot_table_checker
    import stc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  busy,
    input  req_t  req,
    input  logic  done,
    input  rsp_t  rsp,
    output int    errors,
    output int    pending
);

    logic                shadow_valid  [TABLE_ENTRIES];
    logic signed [31:0]  shadow_key    [TABLE_ENTRIES];
    logic [15:0]         shadow_handle [TABLE_ENTRIES];
    logic [TAG_BITS-1:0] shadow_tag    [TABLE_ENTRIES];
    int unsigned         occupied;
    logic [TAG_BITS-1:0] alloc_tag;

    rsp_t rsp_fifo [$];
    rsp_t want;
    int   fail_count;

    // applies one request to the shadow table, returns the result it gives
    function automatic rsp_t table_op_result(input req_t r);
        rsp_t e;
        int   pick;
        e    = '0;
        pick = -1;
        case (func_t'(r.func))
            FN_INSERT, FN_RESERVE:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (!shadow_valid[i] && pick < 0)
                        pick = i;
                if (pick < 0 || occupied >= TABLE_ENTRIES)
                    e.status = STS_MISS;
                else
                begin
                    if (func_t'(r.func) == FN_INSERT)
                    begin
                        shadow_key[pick]    = r.conn_key;
                        shadow_handle[pick] = r.conn_handle;
                    end
                    shadow_valid[pick] = 1'b1;
                    shadow_tag[pick]   = alloc_tag;
                    alloc_tag          = alloc_tag + 1'b1;
                    occupied++;
                    e.slot    = pick[3:0];
                    e.status  = STS_OK;
                    e.seq_tag = 16'(shadow_tag[pick]);
                end
            end
            FN_SEARCH:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (pick < 0 && shadow_valid[i] && shadow_key[i] == r.conn_key)
                        pick = i;
                if (pick < 0)
                    e.status = STS_MISS;
                else
                begin
                    e.slot    = pick[3:0];
                    e.status  = STS_OK;
                    e.seq_tag = 16'(shadow_tag[pick]);
                end
            end
            default:
            begin
                if (r.slot_index >= TABLE_ENTRIES)
                    e.status = STS_RANGE;
                else if (!shadow_valid[r.slot_index])
                    e.status = STS_FREE;
                else
                begin
                    e.slot         = r.slot_index[3:0];
                    e.status       = STS_OK;
                    e.seq_tag      = 16'(shadow_tag[r.slot_index]);
                    e.freed_handle = shadow_handle[r.slot_index];
                    shadow_valid[r.slot_index]  = 1'b0;
                    shadow_key[r.slot_index]    = KEY_NONE;
                    shadow_handle[r.slot_index] = '0;
                    occupied--;
                end
            end
        endcase
        return e;
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                shadow_valid[i]  = 1'b0;
                shadow_key[i]    = KEY_NONE;
                shadow_handle[i] = '0;
                shadow_tag[i]    = '0;
            end
            occupied   = 0;
            alloc_tag  = '0;
            fail_count = 0;
            rsp_fifo.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            // a result on show belongs to an earlier request than one taken now
            if (done)
            begin
                if (rsp_fifo.size() == 0)
                begin
                    $error("result with none expected: slot %0d status %0d",
                           rsp.slot, rsp.status);
                    fail_count++;
                end
                else
                begin
                    want = rsp_fifo.pop_front();
                    check_field("slot", 16'(want.slot), 16'(rsp.slot));
                    check_field("status", 16'(want.status), 16'(rsp.status));
                    check_field("seq_tag", want.seq_tag, rsp.seq_tag);
                    check_field("freed_handle", want.freed_handle, rsp.freed_handle);
                end
            end
            if (start && !busy)
                rsp_fifo.push_back(table_op_result(req));
            errors  <= fail_count;
            pending <= rsp_fifo.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: request generator and verdict for the slot table
// Drives directed then random insert/reserve/search/remove requests with
// random gaps; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_top;
    import stc_pkg::*;

    localparam int RANDOM_REQS = 1250;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req;
    logic  done;
    rsp_t  rsp;
    int    fails;
    int    pending;

    // gaps are suppressed over one stretch so back-to-back requests get hit
    logic  quiet;

    // small key set so searches hit stored entries often
    logic signed [31:0] key_pool [8];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    slot_table_alloc_search uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    slot_table_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .errors  (fails),
        .pending (pending)
    );

    function automatic req_t make_req(input func_t fn, input logic [31:0] key,
                                      input logic [15:0] hdl, input logic [4:0] idx);
        req_t r;
        r.func        = fn;
        r.conn_key    = key;
        r.conn_handle = hdl;
        r.slot_index  = idx;
        return r;
    endfunction

    // Present one request and hold it until the block takes it. A random
    // gap goes in front; since busy covers the run cycle, gaps of different
    // lengths land on the run cycle, the done cycle and beyond.
    task automatic issue_req(input req_t r);
        while (!quiet && $urandom_range(99) < 22)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop sending until every outstanding result is back. The first edge
    // lets the request just taken show up in the pending count.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        case ($urandom_range(9))
            0:       k = KEY_NONE;
            1:       k = 32'h0;
            2:       k = 32'h7FFF_FFFF;
            3, 4, 5, 6, 7:
                     k = key_pool[$urandom_range(7)];
            default:
            begin
                k     = $urandom;
                k[31] = 1'b0;
            end
        endcase
        return k;
    endfunction

    initial
    begin
        func_t       fn;
        int          phase;
        int          roll;
        logic [4:0]  idx;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        quiet = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            key_pool[i]     = $urandom;
            key_pool[i][31] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: empty-table cases ----
        issue_req(make_req(FN_SEARCH, 32'h0, 16'h0, 5'd0));      // key not found
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd0));      // free slot
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd16));     // first out of range
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd31));     // last out of range

        // ---- directed: field extremes, reserve and key -1 matching ----
        issue_req(make_req(FN_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 5'd31));
        issue_req(make_req(FN_INSERT, 32'h0, 16'h0, 5'd0));
        issue_req(make_req(FN_RESERVE, 32'h1234_5678, 16'hA5A5, 5'd7));
        issue_req(make_req(FN_SEARCH, KEY_NONE, 16'h0, 5'd0));   // hits reserved entry
        issue_req(make_req(FN_SEARCH, 32'h7FFF_FFFF, 16'h0, 5'd0));
        issue_req(make_req(FN_INSERT, KEY_NONE, 16'h5A5A, 5'd0));
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd2));      // reserved: handle 0
        issue_req(make_req(FN_SEARCH, KEY_NONE, 16'h0, 5'd0));   // now the inserted -1
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd0));      // returns 16'hFFFF
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd0));      // already freed

        // ---- directed: fill to full, then allocate into a full table ----
        for (int i = 0; i < 14; i++)
            issue_req(make_req((i % 2) ? FN_RESERVE : FN_INSERT, 32'(i + 100),
                               16'($urandom_range(65535)), 5'd0));
        issue_req(make_req(FN_INSERT, 32'h55, 16'h1, 5'd0));     // table full
        issue_req(make_req(FN_RESERVE, 32'h0, 16'h0, 5'd0));     // table full
        issue_req(make_req(FN_REMOVE, 32'h0, 16'h0, 5'd15));
        issue_req(make_req(FN_SEARCH, 32'd104, 16'h0, 5'd0));

        // ---- random: phases swing the table between full and empty ----
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            quiet = (n >= 500 && n < 700);
            if (n == 300 || n == 900)
                drain_results();

            // phases 0,1 favor allocation, 2 is balanced, 3 favors removal
            phase = (n / 100) % 4;
            roll  = $urandom_range(99);
            case (phase)
                0, 1:    fn = (roll < 45) ? FN_INSERT : (roll < 60) ? FN_RESERVE :
                              (roll < 85) ? FN_SEARCH : FN_REMOVE;
                2:       fn = (roll < 25) ? FN_INSERT : (roll < 35) ? FN_RESERVE :
                              (roll < 65) ? FN_SEARCH : FN_REMOVE;
                default: fn = (roll < 12) ? FN_INSERT : (roll < 17) ? FN_RESERVE :
                              (roll < 40) ? FN_SEARCH : FN_REMOVE;
            endcase

            // mostly live slots, sometimes past the end of the table
            if ($urandom_range(99) < 85)
                idx = 5'($urandom_range(TABLE_ENTRIES - 1));
            else
                idx = 5'($urandom_range(31, TABLE_ENTRIES));

            issue_req(make_req(fn, pick_key(), 16'($urandom_range(65535)), idx));
        end

        // ---- wrap-up: collect everything, then watch for strays ----
        quiet = 1'b0;
        drain_results();
        repeat (6) @(posedge clk);
        if (fails == 0)
            $display("PASS slot_table_alloc_search");
        else
            $display("FAIL slot_table_alloc_search");
        $finish;
    end

    // hang guard: far beyond the slowest legal run
    initial
    begin
        #1_000_000;
        $display("FAIL slot_table_alloc_search");
        $finish;
    end

endmodule

// ----- slot_table_alloc_search.f -----
design/stc_pkg.sv
design/stc_cell.sv
design/slot_table_alloc_search.sv
verif/slot_table_checker.sv
verif/tb_top.sv
